FILE: hw/rtl/media_panel_controller_defines.svh
// Assertion macros used by the panel controller top level RTL.
`ifndef MEDIA_PANEL_CONTROLLER_DEFINES_SVH
`define MEDIA_PANEL_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on clk, idle while rst_n is low.
`define MPC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, idle while rst_n is low.
`define MPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mpc_pkg.sv
// Types and constants of the media panel controller.
package mpc_pkg;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PLAY     = 3'd1,
    EV_PAUSE    = 3'd2,
    EV_POSITION = 3'd3,
    EV_VOLUME   = 3'd4,
    EV_NORMAL   = 3'd5,
    EV_PREVIOUS = 3'd6,
    EV_NEXT     = 3'd7
  } panel_event_t;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_VOLUME   = 2'd1,
    MODE_POSITION = 2'd2
  } panel_mode_t;

  localparam int NUM_BUTTONS  = 5;
  localparam int BTN_PLAY     = 0;
  localparam int BTN_POSITION = 1;
  localparam int BTN_VOLUME   = 2;
  localparam int BTN_PREVIOUS = 3;
  localparam int BTN_NEXT     = 4;

  localparam int VOL_W = 7;
  localparam logic [VOL_W-1:0] VOLUME_RESET = 7'd50;
  localparam logic [VOL_W-1:0] LIMIT_RESET  = 7'd100;

  localparam int IN_W  = 8;
  localparam int OUT_W = 16;

  typedef struct packed {
    logic playing;
    logic vol_mode;
    logic pos_mode;
  } panel_flags_t;

endpackage

FILE: hw/rtl/mpc_encoder.sv
// Encoder falling-edge step detect and saturating volume update.
module mpc_encoder (
  input  logic                     enc_a,
  input  logic                     enc_b,
  input  logic                     last_a,
  input  logic                     vol_mode,
  input  logic [mpc_pkg::VOL_W-1:0] volume,
  input  logic [mpc_pkg::VOL_W-1:0] limit,
  output logic signed [1:0]        step_dir,
  output logic [mpc_pkg::VOL_W-1:0] volume_nxt
);
  import mpc_pkg::*;

  logic signed [VOL_W+1:0] sum;

  always_comb begin
    step_dir = 2'sd0;
    if (enc_a != last_a && !enc_a) begin
      step_dir = enc_b ? 2'sd1 : -2'sd1;
    end
  end

  always_comb begin
    sum        = $signed({2'b00, volume}) + (VOL_W+2)'(step_dir);
    volume_nxt = volume;
    if (vol_mode && step_dir != 2'sd0) begin
      if (sum > $signed({2'b00, limit})) begin
        volume_nxt = limit;
      end else if (sum <= 0) begin
        volume_nxt = '0;
      end else begin
        volume_nxt = sum[VOL_W-1:0];
      end
    end
  end

endmodule

FILE: hw/rtl/mpc_buttons.sv
// Prioritized button scan: press detect, mode toggles and event select.
module mpc_buttons (
  input  logic [mpc_pkg::NUM_BUTTONS-1:0] level,
  input  logic [mpc_pkg::NUM_BUTTONS-1:0] held,
  input  mpc_pkg::panel_flags_t           flags,
  output logic [mpc_pkg::NUM_BUTTONS-1:0] held_nxt,
  output mpc_pkg::panel_flags_t           flags_nxt,
  output mpc_pkg::panel_event_t           panel_event
);
  import mpc_pkg::*;

  logic normal;
  logic done;
  logic press;
  logic allowed;

  assign normal = !flags.vol_mode && !flags.pos_mode;

  always_comb begin
    held_nxt    = held;
    flags_nxt   = flags;
    panel_event = EV_NONE;
    done        = 1'b0;
    press       = 1'b0;
    allowed     = 1'b0;
    // Scan in priority order; stop at the first action taken.
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (!done) begin
        press = !level[i] && !held[i];
        if (press) begin
          held_nxt[i] = 1'b1;
        end else if (level[i] && held[i]) begin
          held_nxt[i] = 1'b0;
        end
        case (i)
          BTN_PLAY:     allowed = 1'b1;
          BTN_POSITION: allowed = !flags.vol_mode;
          BTN_VOLUME:   allowed = !flags.pos_mode;
          default:      allowed = normal;
        endcase
        if (press && allowed) begin
          done = 1'b1;
          case (i)
            BTN_PLAY: begin
              flags_nxt.playing = !flags.playing;
              panel_event = flags.playing ? EV_PAUSE : EV_PLAY;
            end
            BTN_POSITION: begin
              flags_nxt.pos_mode = !flags.pos_mode;
              panel_event = flags.pos_mode ? EV_NORMAL : EV_POSITION;
            end
            BTN_VOLUME: begin
              flags_nxt.vol_mode = !flags.vol_mode;
              panel_event = flags.vol_mode ? EV_NORMAL : EV_VOLUME;
            end
            BTN_PREVIOUS: panel_event = EV_PREVIOUS;
            default:      panel_event = EV_NEXT;
          endcase
        end
      end
    end
  end

endmodule

FILE: hw/rtl/media_panel_controller.sv
// Media panel controller top level: request registers, panel state and result register.
// Takes one sampled pin request per clock while in_tready is high and returns one result per
// request: the request lands in an input register, the encoder and button logic update the
// panel state as the result is loaded into an output register, and the result is held there
// until taken. Sustained rate is one request per cycle while out_tready stays high;
// in_tready follows out_tready in the same cycle, so a stalled result stops new requests only
// once the input register is full.
// volume_limit may be rewritten over cfg_we/cfg_wdata while no request is in flight.
`include "media_panel_controller_defines.svh"

module media_panel_controller (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [0] enc_a, [1] enc_b, [2] play_button, [3] position_button, [4] volume_button,
  // [5] previous_button, [6] next_button, [7] zero
  input  logic [mpc_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [2:0] panel_event, [4:3] step_dir, [11:5] volume_level, [12] playing,
  // [14:13] panel_mode, [15] zero
  output logic [mpc_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_we,
  input  logic [mpc_pkg::VOL_W-1:0]  cfg_wdata
);
  import mpc_pkg::*;

  logic                   in_valid_r, in_valid_nxt;
  logic [6:0]             in_data_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r;
  logic                   adv;

  logic [VOL_W-1:0]       limit_r;
  logic                   last_a_r;
  logic [NUM_BUTTONS-1:0] held_r;
  panel_flags_t           flags_r;
  logic [VOL_W-1:0]       volume_r;

  logic signed [1:0]      step_dir;
  logic [VOL_W-1:0]       volume_nxt;
  logic [NUM_BUTTONS-1:0] held_nxt;
  panel_flags_t           flags_nxt;
  panel_event_t           panel_event;
  panel_mode_t            mode_nxt;

  // Advance the input register into the result register when there is room.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  assign in_valid_nxt  = (in_tvalid && in_tready) ? 1'b1 : (adv ? 1'b0 : in_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  mpc_encoder u_encoder (
    .enc_a      (in_data_r[0]),
    .enc_b      (in_data_r[1]),
    .last_a     (last_a_r),
    .vol_mode   (flags_r.vol_mode),
    .volume     (volume_r),
    .limit      (limit_r),
    .step_dir   (step_dir),
    .volume_nxt (volume_nxt)
  );

  mpc_buttons u_buttons (
    .level       (in_data_r[6:2]),
    .held        (held_r),
    .flags       (flags_r),
    .held_nxt    (held_nxt),
    .flags_nxt   (flags_nxt),
    .panel_event (panel_event)
  );

  always_comb begin
    if (flags_nxt.vol_mode) begin
      mode_nxt = MODE_VOLUME;
    end else if (flags_nxt.pos_mode) begin
      mode_nxt = MODE_POSITION;
    end else begin
      mode_nxt = MODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
      last_a_r    <= 1'b1;
      held_r      <= '0;
      flags_r     <= '0;
      volume_r    <= VOLUME_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (adv) begin
        last_a_r <= in_data_r[0];
        held_r   <= held_nxt;
        flags_r  <= flags_nxt;
        volume_r <= volume_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[6:0];
    end
    if (adv) begin
      out_data_r <= {1'b0, mode_nxt, flags_nxt.playing, volume_nxt, step_dir, panel_event};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `MPC_ASSERT(a_modes_exclusive, 1'b1, !(flags_r.vol_mode && flags_r.pos_mode),
              "volume and position modes both set")
  `MPC_ASSERT_NEXT(a_volume_in_limit,
                   adv && flags_r.vol_mode && step_dir != 2'sd0 && !cfg_we,
                   volume_r <= limit_r, "volume step left volume above limit")
  `MPC_ASSERT(a_stall_cause, !in_tready, in_valid_r && out_valid_r && !out_tready,
              "input stalled without a blocked result")
  `MPC_ASSERT(a_step_code, out_valid_r, out_data_r[4:3] != 2'b10,
              "invalid encoder step code in result")

endmodule
